// ===== src/assert_macros.svh =====
// assertion macros shared by the servo move profile rtl
// clocked on clk, disabled while rst_n is low; both names must exist in the user scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ===== src/ssmp_pkg.sv =====
// shared widths, codes, reset values and types for the servo move profile
// no dependencies; imported by the top level
package ssmp_pkg;

    // parameter defaults
    localparam int DUR_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    // field widths
    localparam int POS_W      = 8;
    localparam int PH_W       = 3;
    localparam int RATIO_W    = 9;
    localparam int SLACK_W    = 10;
    localparam int DUR_IN_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // phase codes as seen on the result
    typedef logic [PH_W-1:0] phase_t;
    localparam phase_t PH_IDLE   = 3'd0;
    localparam phase_t PH_SLACK  = 3'd1;
    localparam phase_t PH_ACCEL  = 3'd2;
    localparam phase_t PH_DECEL  = 3'd3;
    localparam phase_t PH_RETURN = 3'd4;

    // op codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_TENSION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_TENSION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATIO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLACK_HOLD   = 3'd4;

    // configuration reset values
    localparam logic [POS_W-1:0]   HOLD_RST     = 8'd90;
    localparam logic [POS_W-1:0]   UP_TEN_RST   = 8'd71;
    localparam logic [POS_W-1:0]   DOWN_TEN_RST = 8'd119;
    localparam logic [RATIO_W-1:0] RATIO_RST    = 9'd128;
    localparam logic [SLACK_W-1:0] SLACK_RST    = 10'd50;

    // ratio of one in Q1.8
    localparam logic [RATIO_W-1:0] RATIO_ONE = 9'd256;

    // one result item
    typedef struct packed {
        logic [POS_W-1:0] pos;
        phase_t           phase;
        logic             busy;
        logic             done;
        logic             rej;
    } result_t;

endpackage

// ===== src/ssmp_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle, num < den assumed
// gives floor(num * 2^QUO_W / den); no package dependency
module ssmp_div #(
    parameter int NUM_W = 16,
    parameter int QUO_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [NUM_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quot
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] den_reg;
    logic [QUO_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [NUM_W:0] shifted;
    logic [NUM_W:0] trial;
    logic           fits;

    // one trial subtraction per cycle
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        trial   = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
    end

    // iteration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
            cnt_reg  <= CNT_W'(QUO_W);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            rem_reg  <= fits ? trial[NUM_W-1:0] : shifted[NUM_W-1:0];
            quot_reg <= {quot_reg[QUO_W-2:0], fits};
            cnt_reg  <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== src/ssmp_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle, lsb first
// after k steps prod = (a * b[k-1:0]) << (B_W - k) + (b >> k); no package dependency
module ssmp_mul #(
    parameter int A_W = 18,
    parameter int B_W = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [A_W-1:0]            a,
    input  logic [B_W-1:0]            b,
    input  logic [$clog2(B_W+1)-1:0]  steps,
    output logic                      done,
    output logic [A_W+B_W-1:0]        prod
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W+B_W-1:0] acc_reg;
    logic [A_W-1:0]     a_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;

    logic [A_W:0]       sum;

    // conditional add into the upper half
    always_comb
    begin
        sum = {1'b0, acc_reg[A_W+B_W-1:B_W]} + (acc_reg[0] ? {1'b0, a_reg} : '0);
    end

    // accumulator and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            acc_reg  <= {{A_W{1'b0}}, b};
            a_reg    <= a;
            cnt_reg  <= steps;
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            acc_reg <= {sum, acc_reg[B_W-1:1]};
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== src/smoothstep_servo_move_profile.sv =====
// top level of the smoothstep servo move profile: phase sequencing and ramp datapath
// uses ssmp_pkg, ssmp_div, ssmp_mul and assert_macros.svh
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------------
//  in      | in_valid / in_stall        | op, target_position, total_duration_ms
//  out     | out_valid / out_stall      | position, phase, busy_res, done_res,
//          |                            | start_rejected
//  cfg     | cfg_wr_en                  | cfg_index, cfg_wdata
//
// a start, slack, return or idle item is written to the result register at its transfer
// a ramp item goes through a serial divide for the progress,
// then three passes through the one shared serial multiplier (square, ease, scale)
// one item at a time: in_stall is high from transfer until the result is loaded into the output register
// the output register frees the input side while a result waits behind out_stall
// rst_n clears the move state and restores the register defaults; no clearing pass
`include "assert_macros.svh"

module smoothstep_servo_move_profile #(
    parameter int DURATION_BITS = ssmp_pkg::DUR_BITS_DEF,
    parameter int FRAC_BITS     = ssmp_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [ssmp_pkg::POS_W-1:0]       target_position,
    input  logic [ssmp_pkg::DUR_IN_W-1:0]    total_duration_ms,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ssmp_pkg::POS_W-1:0]       position,
    output logic [ssmp_pkg::PH_W-1:0]        phase,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             start_rejected,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [ssmp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssmp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import ssmp_pkg::*;

    localparam int DB     = DURATION_BITS;
    localparam int F      = FRAC_BITS;
    localparam int CW     = (DB > SLACK_W) ? DB : SLACK_W;
    localparam int AW     = F + 2;
    localparam int PW     = AW + F;
    localparam int MCNT_W = $clog2(F + 1);
    localparam int SCALE_STEPS = POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SQ,
        S_EASE,
        S_SCALE,
        S_OUT
    } state_t;

    // configuration registers
    logic [POS_W-1:0]   hold_reg;
    logic [POS_W-1:0]   up_ten_reg;
    logic [POS_W-1:0]   down_ten_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [SLACK_W-1:0] slack_reg;

    // move state
    state_t             state_reg;
    phase_t             move_phase_reg;
    logic [DB-1:0]      elapsed_reg;
    logic [DB-1:0]      accel_reg;
    logic [DB-1:0]      decel_reg;
    logic [POS_W-1:0]   target_reg;
    logic [POS_W-1:0]   tension_reg;

    // ramp datapath
    logic [POS_W-1:0]   from_reg;
    logic [POS_W-1:0]   dmag_reg;
    logic               dneg_reg;
    logic [F-1:0]       p_reg;
    result_t            res_reg;
    result_t            out_res_reg;
    logic               out_valid_reg;

    // item decode
    logic [DB-1:0]         dur_in;
    logic [RATIO_W-1:0]    r_sat;
    logic [DB+RATIO_W-1:0] scale_prod;
    logic [DB-1:0]         accel_new;
    logic [DB-1:0]         decel_new;
    logic [POS_W-1:0]      tension_new;
    logic                  start_ok;
    logic                  slack_live;
    logic                  reach_accel;
    logic [DB-1:0]         e_accel;
    logic                  accel_live;
    logic                  reach_decel;
    logic [DB-1:0]         e_decel;
    logic                  decel_live;
    logic                  ret_live;
    logic                  ramp_go;
    logic [DB-1:0]         ramp_e;
    logic [DB-1:0]         ramp_n;
    logic [POS_W-1:0]      ramp_from;
    logic [POS_W-1:0]      ramp_to;
    logic                  in_xfer;

    // shared units
    logic                  div_start;
    logic                  div_done;
    logic [F-1:0]          div_quot;
    logic                  mul_start;
    logic [AW-1:0]         mul_a;
    logic [F-1:0]          mul_b;
    logic [MCNT_W-1:0]     mul_steps;
    logic                  mul_done;
    logic [PW-1:0]         mul_prod;
    logic [AW-1:0]         m_val;
    logic [POS_W-1:0]      scale_mag;
    logic                  scale_frac;
    logic [POS_W-1:0]      pos_calc;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= HOLD_RST;
            up_ten_reg   <= UP_TEN_RST;
            down_ten_reg <= DOWN_TEN_RST;
            ratio_reg    <= RATIO_RST;
            slack_reg    <= SLACK_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_HOLD:         hold_reg     <= cfg_wdata[POS_W-1:0];
                REG_UP_TENSION:   up_ten_reg   <= cfg_wdata[POS_W-1:0];
                REG_DOWN_TENSION: down_ten_reg <= cfg_wdata[POS_W-1:0];
                REG_ACCEL_RATIO:  ratio_reg    <= cfg_wdata[RATIO_W-1:0];
                REG_SLACK_HOLD:   slack_reg    <= cfg_wdata[SLACK_W-1:0];
                default:          ;
            endcase
        end
    end

    // phase walk for the item at the input, zero-length phases fall through
    always_comb
    begin
        dur_in      = DB'(total_duration_ms);
        r_sat       = (ratio_reg > RATIO_ONE) ? RATIO_ONE : ratio_reg;
        scale_prod  = (DB+RATIO_W)'(dur_in) * (DB+RATIO_W)'(r_sat);
        accel_new   = scale_prod[DB+7:8];
        decel_new   = dur_in - accel_new;
        tension_new = (target_position < hold_reg) ? up_ten_reg : down_ten_reg;

        start_ok    = (op == OP_START) && (move_phase_reg == PH_IDLE);
        slack_live  = (move_phase_reg == PH_SLACK) && (CW'(elapsed_reg) < CW'(slack_reg));
        reach_accel = (move_phase_reg == PH_ACCEL) ||
                      ((move_phase_reg == PH_SLACK) && !slack_live);
        e_accel     = (move_phase_reg == PH_ACCEL) ? elapsed_reg : '0;
        accel_live  = reach_accel && (e_accel < accel_reg);
        reach_decel = (move_phase_reg == PH_DECEL) || (reach_accel && !accel_live);
        e_decel     = (move_phase_reg == PH_DECEL) ? elapsed_reg : '0;
        decel_live  = reach_decel && (e_decel < decel_reg);
        ret_live    = (move_phase_reg == PH_RETURN) || (reach_decel && !decel_live);

        ramp_go     = accel_live || decel_live;
        ramp_e      = accel_live ? e_accel : e_decel;
        ramp_n      = accel_live ? accel_reg : decel_reg;
        ramp_from   = accel_live ? tension_reg : target_reg;
        ramp_to     = accel_live ? target_reg : tension_reg;
    end

    assign in_xfer   = in_valid && !in_stall;
    assign div_start = in_xfer && !start_ok && ramp_go;

    // progress p = floor(e * 2^F / n)
    ssmp_div #(
        .NUM_W (DB),
        .QUO_W (F)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ramp_e),
        .den   (ramp_n),
        .done  (div_done),
        .quot  (div_quot)
    );

    // multiplier operand select per pass
    always_comb
    begin
        m_val     = (AW'(3) << F) - AW'({p_reg, 1'b0});
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_steps = MCNT_W'(F);
        case (state_reg)
            S_DIV:
            begin
                mul_start = div_done;
                mul_a     = AW'(div_quot);
                mul_b     = div_quot;
            end
            S_SQ:
            begin
                mul_start = mul_done;
                mul_a     = m_val;
                mul_b     = mul_prod[2*F-1:F];
            end
            S_EASE:
            begin
                mul_start = mul_done;
                mul_a     = AW'(mul_prod[2*F-1:F]);
                mul_b     = F'(dmag_reg);
                mul_steps = MCNT_W'(SCALE_STEPS);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    ssmp_mul #(
        .A_W (AW),
        .B_W (F)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .steps (mul_steps),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // final position with floor toward minus infinity on a falling ramp
    always_comb
    begin
        scale_mag  = mul_prod[2*F-1 -: POS_W];
        scale_frac = |mul_prod[2*F-POS_W-1:0];
        if (dneg_reg)
        begin
            pos_calc = from_reg - scale_mag - POS_W'(scale_frac);
        end
        else
        begin
            pos_calc = from_reg + scale_mag;
        end
    end

    // sequencer, move state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            move_phase_reg <= PH_IDLE;
            elapsed_reg    <= '0;
            accel_reg      <= '0;
            decel_reg      <= '0;
            target_reg     <= '0;
            tension_reg    <= '0;
            from_reg       <= '0;
            dmag_reg       <= '0;
            dneg_reg       <= 1'b0;
            p_reg          <= '0;
            res_reg        <= '0;
            out_res_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // output register: load a finished item or empty on a transfer
            if ((state_reg == S_OUT) && (!out_valid_reg || !out_stall))
            begin
                out_res_reg   <= res_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg   <= (!start_ok && !slack_live && ramp_go) ? S_DIV : S_OUT;
                        res_reg.rej <= (op == OP_START) && !start_ok;
                        if (start_ok)
                        begin
                            target_reg     <= target_position;
                            tension_reg    <= tension_new;
                            accel_reg      <= accel_new;
                            decel_reg      <= decel_new;
                            move_phase_reg <= PH_SLACK;
                            elapsed_reg    <= DB'(1);
                            res_reg.pos    <= tension_new;
                            res_reg.phase  <= PH_SLACK;
                            res_reg.busy   <= 1'b1;
                            res_reg.done   <= 1'b0;
                        end
                        else
                        begin
                            if (slack_live)
                            begin
                                elapsed_reg   <= elapsed_reg + DB'(1);
                                res_reg.pos   <= tension_reg;
                                res_reg.phase <= PH_SLACK;
                                res_reg.busy  <= 1'b1;
                                res_reg.done  <= 1'b0;
                            end
                            else if (ramp_go)
                            begin
                                move_phase_reg <= accel_live ? PH_ACCEL : PH_DECEL;
                                elapsed_reg    <= ramp_e + DB'(1);
                                from_reg       <= ramp_from;
                                dneg_reg       <= ramp_to < ramp_from;
                                dmag_reg       <= (ramp_to < ramp_from) ?
                                                  ramp_from - ramp_to : ramp_to - ramp_from;
                                res_reg.phase  <= accel_live ? PH_ACCEL : PH_DECEL;
                                res_reg.busy   <= 1'b1;
                                res_reg.done   <= 1'b0;
                            end
                            else if (ret_live)
                            begin
                                move_phase_reg <= PH_IDLE;
                                elapsed_reg    <= '0;
                                res_reg.pos    <= hold_reg;
                                res_reg.phase  <= PH_RETURN;
                                res_reg.busy   <= 1'b1;
                                res_reg.done   <= 1'b1;
                            end
                            else
                            begin
                                move_phase_reg <= PH_IDLE;
                                res_reg.pos    <= hold_reg;
                                res_reg.phase  <= PH_IDLE;
                                res_reg.busy   <= 1'b0;
                                res_reg.done   <= 1'b0;
                            end
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        p_reg     <= div_quot;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_EASE;
                    end
                end
                S_EASE:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    if (mul_done)
                    begin
                        res_reg.pos <= pos_calc;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign position       = out_res_reg.pos;
    assign phase          = out_res_reg.phase;
    assign busy_res       = out_res_reg.busy;
    assign done_res       = out_res_reg.done;
    assign start_rejected = out_res_reg.rej;

    // checks
    `ASSERT_NEXT(a_busy_after_xfer, in_valid && !in_stall, in_stall)
    `ASSERT_IMPLY(a_done_on_return, out_valid && done_res, busy_res && (phase == PH_RETURN))
    `ASSERT_IMPLY(a_reject_when_busy, out_valid && start_rejected, busy_res)

endmodule

// ===== bench/servo_profile_checker.sv =====
// servo move profile checker: mirrors the register file, predicts each result from the
// accepted commands and compares every result transfer field by field
// depends on ssmp_pkg for widths, phase codes, register indexes and the result struct
module servo_profile_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            op,
    input  logic [ssmp_pkg::POS_W-1:0]      target_position,
    input  logic [ssmp_pkg::DUR_IN_W-1:0]   total_duration_ms,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [ssmp_pkg::POS_W-1:0]      position,
    input  logic [ssmp_pkg::PH_W-1:0]       phase,
    input  logic                            busy_res,
    input  logic                            done_res,
    input  logic                            start_rejected,
    input  logic                            cfg_wr_en,
    input  logic [ssmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssmp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              mismatches,
    output int                              results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssmp_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int DUR  = DUR_BITS_DEF;

    // register mirror
    logic [POS_W-1:0]   hold_pos;
    logic [POS_W-1:0]   up_ten;
    logic [POS_W-1:0]   down_ten;
    logic [RATIO_W-1:0] ratio_q8;
    logic [SLACK_W-1:0] slack_ms;

    // move state
    phase_t             mv_phase;
    logic [DUR-1:0]     elapsed;
    logic [DUR-1:0]     accel_len;
    logic [DUR-1:0]     decel_len;
    logic [POS_W-1:0]   mv_target;
    logic [POS_W-1:0]   mv_tension;

    // servo commands still owed by the block, oldest first
    result_t servo_cmd_q[$];
    int      fail_cnt;
    int      seen_cnt;

    // smoothstep point of a ramp, Q0.16 progress with floor rounding
    function automatic logic [POS_W-1:0] ease_point(input logic [POS_W-1:0] from_pos,
                                                    input logic [POS_W-1:0] to_pos,
                                                    input logic [DUR-1:0]   step,
                                                    input logic [DUR-1:0]   span);
        longint prog;
        longint sq;
        longint ease;
        longint acc;
        prog = (longint'(step) << FRAC) / longint'(span);
        sq   = (prog * prog) >>> FRAC;
        ease = (sq * ((longint'(3) << FRAC) - 2 * prog)) >>> FRAC;
        acc  = (longint'(from_pos) << FRAC) + (longint'(to_pos) - longint'(from_pos)) * ease;
        if (acc < 0)
        begin
            acc = 0;
        end
        return POS_W'(acc >>> FRAC);
    endfunction

    // advance the move by one command and return the servo command it yields
    function automatic result_t next_servo_cmd(input logic                op_code,
                                               input logic [POS_W-1:0]    tgt,
                                               input logic [DUR_IN_W-1:0] dur);
        result_t                     r;
        logic                        settled;
        logic [RATIO_W-1:0]          ratio_eff;
        logic [DUR_IN_W+RATIO_W-1:0] scaled;
        r.pos   = hold_pos;
        r.phase = PH_IDLE;
        r.busy  = 1'b0;
        r.done  = 1'b0;
        r.rej   = 1'b0;
        // accepted start: latch the move and jump to the tension point
        if (op_code == OP_START && mv_phase == PH_IDLE)
        begin
            ratio_eff  = (ratio_q8 > RATIO_ONE) ? RATIO_ONE : ratio_q8;
            scaled     = dur * ratio_eff;
            mv_target  = tgt;
            mv_tension = (tgt < hold_pos) ? up_ten : down_ten;
            accel_len  = DUR'(scaled >> 8);
            decel_len  = DUR'(dur) - accel_len;
            mv_phase   = PH_SLACK;
            elapsed    = 1;
            r.pos      = mv_tension;
            r.phase    = PH_SLACK;
            r.busy     = 1'b1;
            return r;
        end
        r.rej   = (op_code == OP_START);
        settled = 1'b0;
        // walk through finished or empty phases until one yields a position
        while (!settled)
        begin
            case (mv_phase)
                PH_SLACK:
                begin
                    if (elapsed < slack_ms)
                    begin
                        r.pos   = mv_tension;
                        r.phase = PH_SLACK;
                        r.busy  = 1'b1;
                        elapsed = elapsed + 1'b1;
                        settled = 1'b1;
                    end
                    else
                    begin
                        mv_phase = PH_ACCEL;
                        elapsed  = '0;
                    end
                end
                PH_ACCEL:
                begin
                    if (elapsed < accel_len)
                    begin
                        r.pos   = ease_point(mv_tension, mv_target, elapsed, accel_len);
                        r.phase = PH_ACCEL;
                        r.busy  = 1'b1;
                        elapsed = elapsed + 1'b1;
                        settled = 1'b1;
                    end
                    else
                    begin
                        mv_phase = PH_DECEL;
                        elapsed  = '0;
                    end
                end
                PH_DECEL:
                begin
                    if (elapsed < decel_len)
                    begin
                        r.pos   = ease_point(mv_target, mv_tension, elapsed, decel_len);
                        r.phase = PH_DECEL;
                        r.busy  = 1'b1;
                        elapsed = elapsed + 1'b1;
                        settled = 1'b1;
                    end
                    else
                    begin
                        mv_phase = PH_RETURN;
                        elapsed  = '0;
                    end
                end
                PH_RETURN:
                begin
                    r.pos    = hold_pos;
                    r.phase  = PH_RETURN;
                    r.busy   = 1'b1;
                    r.done   = 1'b1;
                    mv_phase = PH_IDLE;
                    elapsed  = '0;
                    settled  = 1'b1;
                end
                default:
                begin
                    mv_phase = PH_IDLE;
                    settled  = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    // watch register writes, command transfers and result transfers
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            hold_pos     = HOLD_RST;
            up_ten       = UP_TEN_RST;
            down_ten     = DOWN_TEN_RST;
            ratio_q8     = RATIO_RST;
            slack_ms     = SLACK_RST;
            mv_phase     = PH_IDLE;
            elapsed      = '0;
            accel_len    = '0;
            decel_len    = '0;
            mv_target    = '0;
            mv_tension   = '0;
            fail_cnt     = 0;
            seen_cnt     = 0;
            servo_cmd_q.delete();
            mismatches   <= 0;
            results_seen <= 0;
        end
        else
        begin
            // register write
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_HOLD:         hold_pos = cfg_wdata[POS_W-1:0];
                    REG_UP_TENSION:   up_ten   = cfg_wdata[POS_W-1:0];
                    REG_DOWN_TENSION: down_ten = cfg_wdata[POS_W-1:0];
                    REG_ACCEL_RATIO:  ratio_q8 = cfg_wdata[RATIO_W-1:0];
                    REG_SLACK_HOLD:   slack_ms = cfg_wdata[SLACK_W-1:0];
                    default:          ;
                endcase
            end
            // command transfer
            if (in_valid && !in_stall)
            begin
                servo_cmd_q.push_back(next_servo_cmd(op, target_position, total_duration_ms));
            end
            // result transfer
            if (out_valid && !out_stall)
            begin
                got.pos   = position;
                got.phase = phase;
                got.busy  = busy_res;
                got.done  = done_res;
                got.rej   = start_rejected;
                seen_cnt++;
                if (servo_cmd_q.size() == 0)
                begin
                    $error("result transfer with no command outstanding: position %0d phase %0d",
                           got.pos, got.phase);
                    fail_cnt++;
                end
                else
                begin
                    want = servo_cmd_q.pop_front();
                    if (got.pos !== want.pos)
                    begin
                        $error("position: expected %0d, got %0d", want.pos, got.pos);
                        fail_cnt++;
                    end
                    if (got.phase !== want.phase)
                    begin
                        $error("phase: expected %0d, got %0d", want.phase, got.phase);
                        fail_cnt++;
                    end
                    if (got.busy !== want.busy)
                    begin
                        $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
                        fail_cnt++;
                    end
                    if (got.done !== want.done)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done, got.done);
                        fail_cnt++;
                    end
                    if (got.rej !== want.rej)
                    begin
                        $error("start_rejected: expected %0d, got %0d", want.rej, got.rej);
                        fail_cnt++;
                    end
                end
            end
            mismatches   <= fail_cnt;
            results_seen <= seen_cnt;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// top of the servo move profile bench: clock, reset, command and register stimulus,
// randomized stalls on the result side and the final verdict
// depends on ssmp_pkg, smoothstep_servo_move_profile and servo_profile_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssmp_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    logic [POS_W-1:0]      target_position;
    logic [DUR_IN_W-1:0]   total_duration_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic [POS_W-1:0]      position;
    logic [PH_W-1:0]       phase;
    logic                  busy_res;
    logic                  done_res;
    logic                  start_rejected;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_cnt;
    int seen_cnt;
    int sent_cnt    = 0;
    int hold_asks   = 0;
    int hold_served = 0;
    int cur_slack   = SLACK_RST;
    bit gaps_on     = 1'b1;

    always #4 clk = ~clk;

    smoothstep_servo_move_profile DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .target_position   (target_position),
        .total_duration_ms (total_duration_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .position          (position),
        .phase             (phase),
        .busy_res          (busy_res),
        .done_res          (done_res),
        .start_rejected    (start_rejected),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    servo_profile_checker servo_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .target_position   (target_position),
        .total_duration_ms (total_duration_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .position          (position),
        .phase             (phase),
        .busy_res          (busy_res),
        .done_res          (done_res),
        .start_rejected    (start_rejected),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .mismatches        (fail_cnt),
        .results_seen      (seen_cnt)
    );

    // offer one command, optionally after an idle burst, and wait for its transfer
    task automatic send_item(input logic                op_code,
                             input logic [POS_W-1:0]    tgt,
                             input logic [DUR_IN_W-1:0] dur);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        op                <= op_code;
        target_position   <= tgt;
        total_duration_ms <= dur;
        do
            @(posedge clk);
        while (in_stall);
        sent_cnt++;
    endtask

    // stop offering and wait until every command has produced its result
    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (seen_cnt != sent_cnt);
    endtask

    // write all five registers back to back once the block is quiet
    task automatic write_regs(input logic [CFG_DATA_W-1:0] hold,
                              input logic [CFG_DATA_W-1:0] up_t,
                              input logic [CFG_DATA_W-1:0] down_t,
                              input logic [CFG_DATA_W-1:0] ratio,
                              input logic [CFG_DATA_W-1:0] slack);
        wait_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_HOLD;
        cfg_wdata <= hold;
        @(posedge clk);
        cfg_index <= REG_UP_TENSION;
        cfg_wdata <= up_t;
        @(posedge clk);
        cfg_index <= REG_DOWN_TENSION;
        cfg_wdata <= down_t;
        @(posedge clk);
        cfg_index <= REG_ACCEL_RATIO;
        cfg_wdata <= ratio;
        @(posedge clk);
        cfg_index <= REG_SLACK_HOLD;
        cfg_wdata <= slack;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_slack = int'(slack);
    endtask

    // mostly whole moves (start, then about enough ticks to finish) plus stray commands
    task automatic random_moves(input int n_items);
        int                  stop_at;
        int                  ticks;
        int                  k;
        int                  pick;
        logic [POS_W-1:0]    tgt;
        logic [DUR_IN_W-1:0] dur;
        stop_at = sent_cnt + n_items;
        while (sent_cnt < stop_at)
        begin
            tgt  = ($urandom_range(0, 19) == 0) ? POS_W'($urandom_range(0, 255))
                                                : POS_W'($urandom_range(0, 180));
            pick = $urandom_range(0, 99);
            if (pick < 10)
                dur = DUR_IN_W'($urandom_range(0, 3));
            else if (pick < 75)
                dur = DUR_IN_W'($urandom_range(4, 24));
            else if (pick < 97)
                dur = DUR_IN_W'($urandom_range(25, 80));
            else
                dur = DUR_IN_W'($urandom_range(150, 400));
            if ($urandom_range(0, 9) == 0)
            begin
                // stray command
                send_item(($urandom_range(0, 1) == 1) ? OP_START : OP_TICK,
                          POS_W'($urandom_range(0, 255)), DUR_IN_W'($urandom));
            end
            else
            begin
                send_item(OP_START, tgt, dur);
                ticks = ((cur_slack > 1) ? cur_slack - 1 : 0) + int'(dur) + 1
                        + int'($urandom_range(0, 2));
                // sometimes cut short so the next start lands on a busy block
                if ($urandom_range(0, 7) == 0)
                    ticks = ticks - int'($urandom_range(1, 3));
                for (k = 0; k < ticks && sent_cnt < stop_at; k++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        send_item(OP_START, POS_W'($urandom_range(0, 255)),
                                  DUR_IN_W'($urandom));
                    else
                        send_item(OP_TICK, POS_W'($urandom), DUR_IN_W'($urandom));
                end
                if (gaps_on && $urandom_range(0, 9) == 0)
                    wait_results();
            end
        end
    endtask

    // result side: random stall bursts, long hold-offs on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_served != hold_asks)
            begin
                hold_served++;
                out_stall <= 1'b1;
                n = 300;
            end
            else if (gaps_on && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 16);
            end
            else
            begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 24);
            end
            repeat (n) @(posedge clk);
        end
    end

    // command and register stimulus, then the verdict
    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        op                = OP_TICK;
        target_position   = '0;
        total_duration_ms = '0;
        cfg_wr_en         = 1'b0;
        cfg_index         = REG_HOLD;
        cfg_wdata         = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: idle tick, start below hold, then cut slack short live
        send_item(OP_TICK, 8'hFF, 16'hFFFF);
        send_item(OP_START, 8'd10, 16'd4);
        send_item(OP_TICK, 8'd0, 16'd0);
        write_regs(90, 71, 119, 128, 0);
        repeat (6) send_item(OP_TICK, 8'd0, 16'd0);

        // ratio above one, target equal to hold, start while busy, empty ramps
        write_regs(0, 0, 180, 300, 0);
        send_item(OP_START, 8'd0, 16'd3);
        send_item(OP_START, 8'd180, 16'hFFFF);
        repeat (3) send_item(OP_TICK, 8'd0, 16'd0);
        send_item(OP_START, 8'd180, 16'd0);
        send_item(OP_TICK, 8'd0, 16'd0);

        // longest slack, then shortened mid-move; accel ratio zero
        write_regs(180, 0, 180, 0, 1023);
        send_item(OP_START, 8'd179, 16'd5);
        send_item(OP_TICK, 8'd0, 16'd0);
        send_item(OP_START, 8'hFF, 16'h8000);
        write_regs(180, 0, 180, 0, 2);
        repeat (7) send_item(OP_TICK, 8'd0, 16'd0);

        // random phases over several register settings
        write_regs(90, 71, 119, 128, 3);
        random_moves(225);
        write_regs(0, 0, 180, 0, 0);
        random_moves(225);
        write_regs(180, 180, 0, 256, 1);
        random_moves(225);
        write_regs(CFG_DATA_W'($urandom_range(0, 180)), CFG_DATA_W'($urandom_range(0, 180)),
                   CFG_DATA_W'($urandom_range(0, 180)), 511,
                   CFG_DATA_W'($urandom_range(0, 6)));
        hold_asks++;
        random_moves(225);
        write_regs(CFG_DATA_W'($urandom_range(0, 1023)), CFG_DATA_W'($urandom_range(0, 1023)),
                   CFG_DATA_W'($urandom_range(0, 1023)), CFG_DATA_W'($urandom_range(0, 511)),
                   CFG_DATA_W'($urandom_range(0, 6)));
        random_moves(225);
        write_regs(CFG_DATA_W'($urandom_range(0, 180)), CFG_DATA_W'($urandom_range(0, 180)),
                   CFG_DATA_W'($urandom_range(0, 180)), CFG_DATA_W'($urandom_range(0, 511)),
                   CFG_DATA_W'($urandom_range(0, 6)));
        random_moves(225);

        // last stretch without idling on either side
        write_regs(CFG_DATA_W'($urandom_range(0, 180)), CFG_DATA_W'($urandom_range(0, 180)),
                   CFG_DATA_W'($urandom_range(0, 180)), CFG_DATA_W'($urandom_range(0, 256)),
                   CFG_DATA_W'($urandom_range(0, 4)));
        gaps_on = 1'b0;
        random_moves(225);

        wait_results();
        repeat (100) @(posedge clk);
        if (fail_cnt == 0)
            $display("smoothstep_servo_move_profile verification clean");
        else
            $display("smoothstep_servo_move_profile verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(2_000_000 * 8);
        $display("smoothstep_servo_move_profile verification failed");
        $finish;
    end

endmodule
